// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by hual_scan.
// Clocked property checks, reset-qualified or not, that report through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/hual_pkg.sv =====
// Package for the HTTP user-agent locator: payload types, codes, constants.
// Used by hual_scan, http_user_agent_locator and the testbench; depends on nothing.
package hual_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int PosFieldW = 16;
    localparam int MarkW = 32;
    localparam int KeyLen = 14;
    localparam logic [7:0] CrByte = 8'h0D;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NO_HEADER = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FRAGMENT  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_FIRST_COUNT = 2'd0,
        CFG_LAST_COUNT  = 2'd1,
        CFG_NO_UA       = 2'd2,
        CFG_UA          = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             byte_valid;
        logic             last_byte;
        logic             ct_present;
        logic             mark_present;
        logic [MarkW-1:0] ct_mark;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [PosFieldW-1:0] value_offset;
        logic [PosFieldW-1:0] value_length;
        logic                 mark_write;
        logic [MarkW-1:0]     new_mark;
        logic                 confirmed_no_ua;
    } t_out_item;

    typedef struct packed {
        logic                 step;
        logic                 last;
        logic [7:0]           data_byte;
    } t_scan_ctl;

    typedef struct packed {
        logic                 header_found;
        logic                 terminator_found;
        logic [PosFieldW-1:0] length;
        logic [PosFieldW-1:0] value_start;
        logic [PosFieldW-1:0] found_length;
    } t_scan_sum;

    function automatic logic [7:0] key_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h0D;
            4'd1:    b = 8'h0A;
            4'd2:    b = 8'h75;
            4'd3:    b = 8'h73;
            4'd4:    b = 8'h65;
            4'd5:    b = 8'h72;
            4'd6:    b = 8'h2D;
            4'd7:    b = 8'h61;
            4'd8:    b = 8'h67;
            4'd9:    b = 8'h65;
            4'd10:   b = 8'h6E;
            4'd11:   b = 8'h74;
            4'd12:   b = 8'h3A;
            4'd13:   b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/hual_scan.sv =====
// Per-byte header scan: key match, position count, value start and CR search.
// Depends on hual_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hual_scan #(
    parameter int POSITION_BITS = hual_pkg::POSITION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hual_pkg::t_scan_ctl i_ctl,
    output hual_pkg::t_scan_sum o_sum
);
    import hual_pkg::*;

    localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};
    localparam logic [3:0] KeyLast = 4'(KeyLen);

    logic [3:0]               r_match, n_match;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic                     r_header_found, n_header_found;
    logic [POSITION_BITS-1:0] r_value_start, n_value_start;
    logic                     r_term_found, n_term_found;
    logic [POSITION_BITS-1:0] r_found_len, n_found_len;

    logic [3:0]               s_match;
    logic [POSITION_BITS-1:0] s_pos;
    logic                     s_header_found;
    logic [POSITION_BITS-1:0] s_value_start;
    logic                     s_term_found;
    logic [POSITION_BITS-1:0] s_found_len;

    always_comb begin
        logic [3:0] mp;
        logic [7:0] b;
        mp = r_match;
        b  = i_ctl.data_byte;
        s_match        = r_match;
        s_pos          = r_pos;
        s_header_found = r_header_found;
        s_value_start  = r_value_start;
        s_term_found   = r_term_found;
        s_found_len    = r_found_len;
        if (i_ctl.step) begin
            if (!r_header_found) begin
                if (mp >= KeyLast) begin
                    mp = 4'd0;
                end
                if (fold_case(b) == key_byte(mp)) begin
                    mp = mp + 4'd1;
                    if (mp == KeyLast) begin
                        s_header_found = 1'b1;
                        s_value_start  = (r_pos != PosMax) ? r_pos + 1'b1 : PosMax;
                        mp = 4'd0;
                    end
                end else begin
                    mp = (b == CrByte) ? 4'd1 : 4'd0;
                end
                s_match = mp;
            end else if (!r_term_found && b == CrByte && r_pos >= r_value_start) begin
                s_term_found = 1'b1;
                s_found_len  = r_pos - r_value_start;
            end
            if (r_pos != PosMax) begin
                s_pos = r_pos + 1'b1;
            end
        end
    end

    always_comb begin
        if (i_ctl.last) begin
            n_match        = '0;
            n_pos          = '0;
            n_header_found = 1'b0;
            n_value_start  = '0;
            n_term_found   = 1'b0;
            n_found_len    = '0;
        end else begin
            n_match        = s_match;
            n_pos          = s_pos;
            n_header_found = s_header_found;
            n_value_start  = s_value_start;
            n_term_found   = s_term_found;
            n_found_len    = s_found_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match        <= '0;
            r_pos          <= '0;
            r_header_found <= 1'b0;
            r_value_start  <= '0;
            r_term_found   <= 1'b0;
            r_found_len    <= '0;
        end else begin
            r_match        <= n_match;
            r_pos          <= n_pos;
            r_header_found <= n_header_found;
            r_value_start  <= n_value_start;
            r_term_found   <= n_term_found;
            r_found_len    <= n_found_len;
        end
    end

    assign o_sum.header_found     = s_header_found;
    assign o_sum.terminator_found = s_term_found;
    assign o_sum.length           = PosFieldW'(s_pos);
    assign o_sum.value_start      = PosFieldW'(s_value_start);
    assign o_sum.found_length     = PosFieldW'(s_found_len);

    `ASSERT_CLK(a_match_range, i_clk, i_rst_n, r_match < KeyLast,
        "match progress beyond key length")
    `ASSERT_CLK(a_term_needs_header, i_clk, i_rst_n, !r_term_found || r_header_found,
        "terminator recorded without header")
    `ASSERT_CLK(a_clear_after_last, i_clk, i_rst_n,
        i_ctl.last |=> (r_pos == '0 && !r_header_found && r_match == 4'd0),
        "packet state not cleared after last transaction")
    `ASSERT_CLK(a_len_within_pos, i_clk, i_rst_n,
        r_term_found |-> ({1'b0, r_value_start} + {1'b0, r_found_len} <= {1'b0, r_pos}),
        "value length runs past bytes seen")
endmodule

// ===== rtl/core/http_user_agent_locator.sv =====
// Top level of the HTTP user-agent locator: handshakes, config, status, mark.
// Depends on hual_pkg and hual_scan.
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid/o_in_ready   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid/i_out_ready | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One transaction per cycle: input register, then one pass of scan and mark
// logic into the result register; the key compare and 32-bit mark compares set
// the path. A stalled result holds only transactions that end a packet; other
// transactions keep flowing. Reset is synchronous; marks return to 16, 40, 43
// and 44.
module http_user_agent_locator #(
    parameter int POSITION_BITS = hual_pkg::POSITION_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  hual_pkg::t_in_item     i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output hual_pkg::t_out_item    o_out_item,
    input  logic                   i_cfg_we,
    input  hual_pkg::t_cfg_index   i_cfg_index,
    input  logic [hual_pkg::MarkW-1:0] i_cfg_data
);
    import hual_pkg::*;

    logic [MarkW-1:0] r_first_count, r_last_count, r_no_ua, r_ua;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item, n_out_item;
    logic       advance;
    t_scan_ctl  scan_ctl;
    t_scan_sum  scan_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_count <= MarkW'(16);
            r_last_count  <= MarkW'(40);
            r_no_ua       <= MarkW'(43);
            r_ua          <= MarkW'(44);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_COUNT: r_first_count <= i_cfg_data;
                CFG_LAST_COUNT:  r_last_count  <= i_cfg_data;
                CFG_NO_UA:       r_no_ua       <= i_cfg_data;
                CFG_UA:          r_ua          <= i_cfg_data;
                default:         r_ua          <= r_ua;
            endcase
        end
    end

    assign advance    = r_in_valid && (!r_in_item.last_byte || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    assign scan_ctl.step      = advance && r_in_item.byte_valid;
    assign scan_ctl.last      = advance && r_in_item.last_byte;
    assign scan_ctl.data_byte = r_in_item.data_byte;

    hual_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .o_sum   (scan_sum)
    );

    always_comb begin
        logic [MarkW-1:0]   mark;
        logic [PosFieldW:0] need;
        n_out_item = '0;
        need = {1'b0, scan_sum.value_start} + (PosFieldW+1)'(2);
        if (!scan_sum.header_found) begin
            n_out_item.status = ST_NO_HEADER;
        end else begin
            n_out_item.value_offset = scan_sum.value_start;
            if ({1'b0, scan_sum.length} < need) begin
                n_out_item.status = ST_EMPTY;
            end else if (!scan_sum.terminator_found || scan_sum.found_length == '0) begin
                n_out_item.status = ST_FRAGMENT;
            end else begin
                n_out_item.status       = ST_FOUND;
                n_out_item.value_length = scan_sum.found_length;
            end
        end

        if (r_in_item.ct_present) begin
            mark = r_in_item.mark_present ? r_in_item.ct_mark : MarkW'(1);
        end else begin
            mark = '0;
        end

        if (!scan_sum.header_found) begin
            if (mark == MarkW'(1)) begin
                n_out_item.mark_write = 1'b1;
                n_out_item.new_mark   = r_first_count;
            end
            if (mark >= r_first_count && mark <= r_last_count) begin
                n_out_item.mark_write = 1'b1;
                n_out_item.new_mark   = mark + MarkW'(1);
            end
            if (mark == r_last_count + MarkW'(1)) begin
                n_out_item.mark_write      = 1'b1;
                n_out_item.new_mark        = r_no_ua;
                n_out_item.confirmed_no_ua = 1'b1;
            end
        end else if (mark != r_ua) begin
            n_out_item.mark_write = 1'b1;
            n_out_item.new_mark   = r_ua;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (scan_ctl.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_ctl.last) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
endmodule

// ===== tb/sv/ua_report_checker.sv =====
`timescale 1ns / 100ps
// Result checker for http_user_agent_locator: watches the input, output and config ports,
// predicts each packet's report and compares it field by field. Depends on hual_pkg.
module ua_report_checker #(
    parameter int POSITION_BITS = hual_pkg::POSITION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  hual_pkg::t_in_item             i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  hual_pkg::t_out_item            i_out_item,
    input  logic                           i_cfg_we,
    input  hual_pkg::t_cfg_index           i_cfg_index,
    input  logic [hual_pkg::MarkW-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import hual_pkg::*;

    localparam logic [PosFieldW-1:0] PosLimit = PosFieldW'((32'd1 << POSITION_BITS) - 32'd1);
    localparam logic [8*KeyLen-1:0] UaKey = {8'h0D, 8'h0A, "user-agent: "};

    logic [MarkW-1:0] first_count;
    logic [MarkW-1:0] last_count;
    logic [MarkW-1:0] no_ua;
    logic [MarkW-1:0] ua;

    logic [3:0]           key_idx;
    logic [PosFieldW-1:0] scan_pos;
    logic                 hdr_seen;
    logic [PosFieldW-1:0] val_start;
    logic                 cr_seen;
    logic [PosFieldW-1:0] val_len;

    t_out_item ua_reports[$];
    int        mismatches = 0;

    task automatic clear_scan();
        key_idx   = '0;
        scan_pos  = '0;
        hdr_seen  = 1'b0;
        val_start = '0;
        cr_seen   = 1'b0;
        val_len   = '0;
    endtask

    task automatic locate_ua(input t_in_item it);
        logic [PosFieldW-1:0] pos;
        logic [7:0]           lc;
        logic [MarkW-1:0]     mark;
        t_out_item            res;
        pos = scan_pos;
        if (it.byte_valid) begin
            if (!hdr_seen) begin
                lc = (it.data_byte >= 8'h41 && it.data_byte <= 8'h5A) ?
                     it.data_byte + 8'h20 : it.data_byte;
                if (lc == UaKey[8*(KeyLen-1-int'(key_idx)) +: 8]) begin
                    if (key_idx == 4'(KeyLen - 1)) begin
                        hdr_seen  = 1'b1;
                        val_start = (pos < PosLimit) ? pos + 1'b1 : PosLimit;
                        key_idx   = '0;
                    end else begin
                        key_idx = key_idx + 4'd1;
                    end
                end else begin
                    key_idx = (it.data_byte == CrByte) ? 4'd1 : 4'd0;
                end
            end else if (!cr_seen && it.data_byte == CrByte && pos >= val_start) begin
                cr_seen = 1'b1;
                val_len = pos - val_start;
            end
            scan_pos = (pos < PosLimit) ? pos + 1'b1 : PosLimit;
        end
        if (it.last_byte) begin
            res = '0;
            if (!it.ct_present) begin
                mark = '0;
            end else if (!it.mark_present) begin
                mark = 32'd1;
            end else begin
                mark = it.ct_mark;
            end
            if (!hdr_seen) begin
                res.status = ST_NO_HEADER;
                if (mark == 32'd1) begin
                    res.mark_write = 1'b1;
                    res.new_mark   = first_count;
                end
                if (mark >= first_count && mark <= last_count) begin
                    res.mark_write = 1'b1;
                    res.new_mark   = mark + 32'd1;
                end
                if (mark == last_count + 32'd1) begin
                    res.mark_write      = 1'b1;
                    res.new_mark        = no_ua;
                    res.confirmed_no_ua = 1'b1;
                end
            end else begin
                res.value_offset = val_start;
                if ({1'b0, scan_pos} < {1'b0, val_start} + 17'd2) begin
                    res.status = ST_EMPTY;
                end else if (!cr_seen || val_len == '0) begin
                    res.status = ST_FRAGMENT;
                end else begin
                    res.status       = ST_FOUND;
                    res.value_length = val_len;
                end
                if (mark != ua) begin
                    res.mark_write = 1'b1;
                    res.new_mark   = ua;
                end
            end
            ua_reports.push_back(res);
            clear_scan();
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_report(input t_out_item got);
        t_out_item want;
        if (ua_reports.size() == 0) begin
            $display("%0t: report expected none actual status %0d new_mark 0x%0h",
                     $time, got.status, got.new_mark);
            mismatches++;
        end else begin
            want = ua_reports.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("value_offset", 32'(want.value_offset), 32'(got.value_offset));
            compare_field("value_length", 32'(want.value_length), 32'(got.value_length));
            compare_field("mark_write", 32'(want.mark_write), 32'(got.mark_write));
            compare_field("new_mark", want.new_mark, got.new_mark);
            compare_field("confirmed_no_ua", 32'(want.confirmed_no_ua),
                          32'(got.confirmed_no_ua));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            first_count = 32'd16;
            last_count  = 32'd40;
            no_ua       = 32'd43;
            ua          = 32'd44;
            clear_scan();
            ua_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIRST_COUNT: first_count = i_cfg_data;
                    CFG_LAST_COUNT:  last_count  = i_cfg_data;
                    CFG_NO_UA:       no_ua       = i_cfg_data;
                    CFG_UA:          ua          = i_cfg_data;
                    default:         ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                locate_ua(i_in_item);
            end
            if (i_out_valid && i_out_ready) begin
                check_report(i_out_item);
            end
        end
        o_pending    = ua_reports.size();
        o_fail_count = mismatches;
    end

endmodule

// ===== tb/sv/tb_http_user_agent_locator.sv =====
`timescale 1ns / 100ps
// Testbench top for http_user_agent_locator: clock, reset, packet stimulus and mark settings.
// Depends on hual_pkg, the block and ua_report_checker, which predicts and compares.
module tb_http_user_agent_locator;
    import hual_pkg::*;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_item         in_item   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_item        out_item;
    logic             cfg_we    = 1'b0;
    t_cfg_index       cfg_index = CFG_FIRST_COUNT;
    logic [MarkW-1:0] cfg_data  = '0;
    int               fail_count;
    int               pending;

    logic             idle_on    = 1'b1;
    int               items_sent = 0;
    logic [MarkW-1:0] first_mark = 32'd16;
    logic [MarkW-1:0] last_mark  = 32'd40;
    logic [MarkW-1:0] ua_mark    = 32'd44;
    logic [7:0]       pkt[$];

    http_user_agent_locator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ua_report_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_ready <= !(idle_on && $urandom_range(99) < 30);
    end

    function automatic t_in_item make_item(input logic [7:0] b, input logic bv,
                                           input logic lst);
        t_in_item it;
        it.data_byte    = b;
        it.byte_valid   = bv;
        it.last_byte    = lst;
        it.ct_present   = 1'($urandom_range(1));
        it.mark_present = 1'($urandom_range(1));
        it.ct_mark      = $urandom;
        return it;
    endfunction

    task automatic put_item(input t_in_item it);
        while (idle_on && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (it.byte_valid || it.last_byte) items_sent++;
    endtask

    task automatic send_packet(input logic ctp, input logic mkp, input logic [MarkW-1:0] mark);
        t_in_item fin;
        logic     late_end;
        late_end = (pkt.size() == 0) || ($urandom_range(9) == 0);
        fin = make_item(8'($urandom_range(255)), 1'b0, 1'b1);
        fin.ct_present   = ctp;
        fin.mark_present = mkp;
        fin.ct_mark      = mark;
        foreach (pkt[i]) begin
            if ($urandom_range(9) == 0) begin
                put_item(make_item(8'($urandom_range(255)), 1'b0, 1'b0));
            end
            if (i == pkt.size() - 1 && !late_end) begin
                fin.data_byte  = pkt[i];
                fin.byte_valid = 1'b1;
                put_item(fin);
            end else begin
                put_item(make_item(pkt[i], 1'b1, 1'b0));
            end
        end
        if (late_end) put_item(fin);
        pkt.delete();
    endtask

    task automatic send_random_mark();
        logic [MarkW-1:0] m;
        logic [MarkW-1:0] span;
        logic             ctp;
        logic             mkp;
        ctp  = 1'b1;
        mkp  = 1'b1;
        span = last_mark - first_mark;
        case ($urandom_range(9))
            0: begin
                mkp = 1'b0;
                m   = $urandom;
            end
            1: m = 32'd1;
            2: m = first_mark;
            3: m = last_mark;
            4: m = last_mark + 32'd1;
            5: m = ua_mark;
            6: begin
                ctp = 1'b0;
                mkp = 1'($urandom_range(1));
                m   = $urandom;
            end
            7: m = first_mark + ((span == '1) ? $urandom : $urandom_range(span));
            8: m = first_mark - 32'd1;
            default: m = $urandom;
        endcase
        send_packet(ctp, mkp, m);
    endtask

    task automatic push_text(input int n);
        repeat (n) pkt.push_back(8'($urandom_range(126, 32)));
    endtask

    task automatic push_noise(input int n);
        repeat (n) pkt.push_back(8'($urandom_range(255)));
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
    endtask

    task automatic push_key(input int cut, input int flip);
        logic [8*12-1:0] hdr_name;
        logic [7:0]      c;
        hdr_name = "User-Agent: ";
        for (int i = 0; i < cut; i++) begin
            if (i == 0) begin
                c = CrByte;
            end else if (i == 1) begin
                c = 8'h0A;
            end else begin
                c = hdr_name[8*(13-i) +: 8];
            end
            if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A) begin
                c = $urandom_range(1) ? (c | 8'h20) : (c & 8'hDF);
            end
            if (i == flip) c = c ^ 8'h01;
            pkt.push_back(c);
        end
    endtask

    task automatic build_random_packet();
        int sel;
        int flip;
        sel  = $urandom_range(99);
        flip = -1;
        if (sel < 55) begin
            push_text($urandom_range(6));
            if ($urandom_range(3) == 0) push_noise($urandom_range(3));
            push_key(KeyLen, -1);
            push_text(($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(3));
            if ($urandom_range(3) != 0) begin
                pkt.push_back(CrByte);
                pkt.push_back(8'h0A);
                push_text($urandom_range(8));
            end
        end else if (sel < 70) begin
            push_text($urandom_range(30));
        end else if (sel < 82) begin
            push_text($urandom_range(4));
            if ($urandom_range(1)) flip = $urandom_range(KeyLen - 1);
            push_key($urandom_range(KeyLen), flip);
            push_text($urandom_range(6));
            if ($urandom_range(1)) begin
                push_key(KeyLen, -1);
                push_text($urandom_range(4));
                pkt.push_back(CrByte);
            end
        end else if (sel < 92) begin
            push_noise($urandom_range(24));
        end
    endtask

    task automatic random_phase(input int count);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop) begin
            build_random_packet();
            send_random_mark();
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_marks(input logic [MarkW-1:0] first, input logic [MarkW-1:0] last,
                              input logic [MarkW-1:0] no_ua, input logic [MarkW-1:0] ua);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIRST_COUNT;
        cfg_data  <= first;
        @(negedge clk);
        cfg_index <= CFG_LAST_COUNT;
        cfg_data  <= last;
        @(negedge clk);
        cfg_index <= CFG_NO_UA;
        cfg_data  <= no_ua;
        @(negedge clk);
        cfg_index <= CFG_UA;
        cfg_data  <= ua;
        @(negedge clk);
        cfg_we     <= 1'b0;
        first_mark = first;
        last_mark  = last;
        ua_mark    = ua;
        @(negedge clk);
    endtask

    task automatic run_directed();
        send_packet(1'b1, 1'b0, 32'd0);
        push_key(KeyLen, -1);
        push_str("ab");
        pkt.push_back(CrByte);
        pkt.push_back(8'h0A);
        send_packet(1'b1, 1'b1, 32'd44);
        push_key(KeyLen, -1);
        pkt.push_back(CrByte);
        push_str("x");
        send_packet(1'b0, 1'b1, 32'd44);
        push_key(KeyLen, -1);
        send_packet(1'b1, 1'b1, 32'd1);
        push_key(KeyLen, -1);
        push_str("x");
        send_packet(1'b1, 1'b1, 32'd40);
        push_key(KeyLen, -1);
        push_str("xy");
        send_packet(1'b1, 1'b1, 32'hFFFF_FFFF);
        pkt.push_back(CrByte);
        pkt.push_back(8'h0A);
        push_key(KeyLen, -1);
        push_str("v");
        pkt.push_back(CrByte);
        send_packet(1'b1, 1'b1, 32'd0);
        push_str("GET / HTTP/1.1");
        pkt.push_back(CrByte);
        pkt.push_back(8'h0A);
        push_str("Host: a");
        send_packet(1'b1, 1'b1, 32'd1);
        pkt.push_back(8'h00);
        pkt.push_back(8'hFF);
        push_noise(6);
        send_packet(1'b1, 1'b1, 32'd16);
        push_text(5);
        send_packet(1'b1, 1'b1, 32'd41);
        push_text(5);
        send_packet(1'b1, 1'b1, 32'd42);
        push_text(3);
        send_packet(1'b1, 1'b1, 32'd15);
        push_key(9, -1);
        send_packet(1'b0, 1'b0, 32'd20);
        push_key(KeyLen, 7);
        push_text(4);
        send_packet(1'b1, 1'b1, 32'd39);
        push_key(KeyLen, -1);
        push_str("one");
        pkt.push_back(CrByte);
        push_key(KeyLen, -1);
        push_str("zz");
        pkt.push_back(CrByte);
        send_packet(1'b1, 1'b1, 32'd7);
        drain();
    endtask

    initial begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        drain();
        load_marks($urandom_range(30, 2), $urandom_range(60, 20), $urandom_range(80),
                   $urandom_range(80));
        random_phase(500);
        drain();
        load_marks(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        random_phase(400);
        drain();
        load_marks(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
        random_phase(300);
        drain();
        idle_on <= 1'b0;
        load_marks(32'd16, 32'd40, 32'd43, 32'd44);
        random_phase(400);
        drain();
        idle_on <= 1'b1;
        load_marks($urandom_range(10, 1), $urandom_range(20, 5), $urandom_range(40),
                   $urandom_range(40));
        random_phase(400);
        drain();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/hual_pkg.sv
rtl/core/hual_scan.sv
rtl/core/http_user_agent_locator.sv
tb/sv/ua_report_checker.sv
tb/sv/tb_http_user_agent_locator.sv
